// ===== design/trqc_pkg.sv =====
// Shared types, constants and helpers of the track rms quality check.
package trqc_pkg;

	localparam int ResidW = 20;
	localparam int LatW = 14;
	localparam int CntW = 13;
	localparam int SumW = 51;
	localparam int SqW = 40;
	localparam int RootW = 26;
	localparam int MaxTrackLen = 4096;
	localparam logic [CntW-1:0] CountCap =
		CntW'((MaxTrackLen < 8191) ? MaxTrackLen : 8191);

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_FEW = 2'd1;
	localparam logic [1:0] VERDICT_LIMIT = 2'd2;

	localparam logic [2:0] REG_WIN_LOW = 3'd0;
	localparam logic [2:0] REG_WIN_HIGH = 3'd1;
	localparam logic [2:0] REG_LIM_X = 3'd2;
	localparam logic [2:0] REG_LIM_Y = 3'd3;
	localparam logic [2:0] REG_LIM_Z = 3'd4;
	localparam logic [2:0] REG_LIM_F = 3'd5;
	localparam logic [2:0] REG_MIN_CNT = 3'd6;

	typedef struct packed {
		logic [CntW-1:0] window_low;
		logic [CntW-1:0] window_high;
		logic [ResidW-1:0] limit_x;
		logic [ResidW-1:0] limit_y;
		logic [ResidW-1:0] limit_z;
		logic [ResidW-1:0] limit_f;
		logic [CntW-1:0] min_scalar_count;
	} cfg_t;

	typedef struct packed {
		logic accum;
		logic load;
		logic div_step;
		logic sqrt_step;
		logic next_comp;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic last_done;
		logic [1:0] comp;
	} sts_t;

	function automatic logic [ResidW-1:0] magnitude(input logic [ResidW-1:0] v);
		return v[ResidW-1] ? ResidW'(-v) : v;
	endfunction

endpackage

// ===== design/trqc_regs.sv =====
// Configuration register file with an APB-style access port.
module trqc_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output trqc_pkg::cfg_t cfg
);
	import trqc_pkg::*;

	cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low <= '0;
			cfg_q.window_high <= CntW'(3520);
			cfg_q.limit_x <= '0;
			cfg_q.limit_y <= '0;
			cfg_q.limit_z <= '0;
			cfg_q.limit_f <= '0;
			cfg_q.min_scalar_count <= CntW'(10);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (idx)
				REG_WIN_LOW: cfg_q.window_low <= pwdata[CntW-1:0];
				REG_WIN_HIGH: cfg_q.window_high <= pwdata[CntW-1:0];
				REG_LIM_X: cfg_q.limit_x <= pwdata[ResidW-1:0];
				REG_LIM_Y: cfg_q.limit_y <= pwdata[ResidW-1:0];
				REG_LIM_Z: cfg_q.limit_z <= pwdata[ResidW-1:0];
				REG_LIM_F: cfg_q.limit_f <= pwdata[ResidW-1:0];
				REG_MIN_CNT: cfg_q.min_scalar_count <= pwdata[CntW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIN_LOW: prdata = 32'(cfg_q.window_low);
			REG_WIN_HIGH: prdata = 32'(cfg_q.window_high);
			REG_LIM_X: prdata = 32'(cfg_q.limit_x);
			REG_LIM_Y: prdata = 32'(cfg_q.limit_y);
			REG_LIM_Z: prdata = 32'(cfg_q.limit_z);
			REG_LIM_F: prdata = 32'(cfg_q.limit_f);
			REG_MIN_CNT: prdata = 32'(cfg_q.min_scalar_count);
			default: prdata = '0;
		endcase
	end
endmodule

// ===== design/trqc_datapath.sv =====
// Accumulators, shared restoring divider and square root, and result register.
module trqc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  trqc_pkg::cfg_t cfg,
	input  trqc_pkg::cmd_t cmd,
	output trqc_pkg::sts_t sts,
	input  logic [100:0] in_data,
	output logic [111:0] res_data
);
	import trqc_pkg::*;

	logic [ResidW-1:0] rx, ry, rz, rf;
	logic [LatW-1:0] lat;
	logic bad, vec, last;
	logic [LatW-1:0] abs_lat;
	logic keep;
	logic [SqW-1:0] sqx_s1, sqy_s1, sqz_s1, sqf_s1;
	logic addv_s1, adds_s1, last_s1;
	logic [SumW-1:0] sumx_q, sumy_q, sumz_q, sumf_q;
	logic [CntW-1:0] cntv_q, cnts_q;
	logic [CntW-1:0] cntv_nx, cnts_nx;
	logic [SumW-1:0] rem_q, quo_q;
	logic [SumW:0] rem_sh;
	logic [2*RootW-1:0] val_q;
	logic [RootW-1:0] root_q;
	logic [RootW+1:0] sq_rem_q, sq_trial, sq_shift;
	logic [1:0] comp_q;
	logic [ResidW-1:0] rms_q [4];
	logic [CntW-1:0] div_cnt;
	logic [1:0] verdict;
	logic over;

	assign rx = in_data[19:0];
	assign ry = in_data[39:20];
	assign rz = in_data[59:40];
	assign rf = in_data[79:60];
	assign lat = in_data[93:80];
	assign bad = in_data[94];
	assign vec = in_data[95];
	assign last = in_data[96];
	assign abs_lat = lat[LatW-1] ? LatW'(-lat) : lat;
	assign keep = !bad && (abs_lat >= LatW'(cfg.window_low))
		&& (abs_lat <= LatW'(cfg.window_high));
	assign cntv_nx = cntv_q + CntW'(addv_s1);
	assign cnts_nx = cnts_q + CntW'(adds_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addv_s1 <= 1'b0;
			adds_s1 <= 1'b0;
			last_s1 <= 1'b0;
			sumx_q <= '0;
			sumy_q <= '0;
			sumz_q <= '0;
			sumf_q <= '0;
			cntv_q <= '0;
			cnts_q <= '0;
			comp_q <= '0;
		end else begin
			addv_s1 <= cmd.accum && keep && vec && cntv_nx < CountCap
				&& !(addv_s1 && cntv_nx == CountCap);
			adds_s1 <= cmd.accum && keep && cnts_nx < CountCap;
			last_s1 <= cmd.accum && last;
			if (cmd.clear) begin
				sumx_q <= '0;
				sumy_q <= '0;
				sumz_q <= '0;
				sumf_q <= '0;
				cntv_q <= '0;
				cnts_q <= '0;
				comp_q <= '0;
			end else begin
				if (addv_s1) begin
					sumx_q <= sumx_q + SumW'(sqx_s1);
					sumy_q <= sumy_q + SumW'(sqy_s1);
					sumz_q <= sumz_q + SumW'(sqz_s1);
				end
				if (adds_s1)
					sumf_q <= sumf_q + SumW'(sqf_s1);
				cntv_q <= cntv_nx;
				cnts_q <= cnts_nx;
				if (cmd.next_comp)
					comp_q <= comp_q + 2'd1;
			end
		end
	end

	// Capacity check above looks at the count after the stage-one add lands.
	always_ff @(posedge clk) begin
		sqx_s1 <= magnitude(rx) * magnitude(rx);
		sqy_s1 <= magnitude(ry) * magnitude(ry);
		sqz_s1 <= magnitude(rz) * magnitude(rz);
		sqf_s1 <= magnitude(rf) * magnitude(rf);
	end

	assign div_cnt = (comp_q == 2'd3) ? cnts_q : cntv_q;
	assign rem_sh = {rem_q, quo_q[SumW-1]};
	assign sq_shift = {sq_rem_q[RootW-1:0], val_q[2*RootW-1 -: 2]};
	assign sq_trial = sq_shift - {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			case (comp_q)
				2'd0: quo_q <= sumx_q;
				2'd1: quo_q <= sumy_q;
				2'd2: quo_q <= sumz_q;
				default: quo_q <= sumf_q;
			endcase
			root_q <= '0;
			sq_rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= (SumW+1)'(div_cnt)) begin
				rem_q <= SumW'(rem_sh - (SumW+1)'(div_cnt));
				quo_q <= {quo_q[SumW-2:0], 1'b1};
				val_q <= (2*RootW)'({quo_q[SumW-2:0], 1'b1});
			end else begin
				rem_q <= rem_sh[SumW-1:0];
				quo_q <= {quo_q[SumW-2:0], 1'b0};
				val_q <= (2*RootW)'({quo_q[SumW-2:0], 1'b0});
			end
		end else if (cmd.sqrt_step) begin
			if (!sq_trial[RootW+1]) begin
				sq_rem_q <= sq_trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				sq_rem_q <= sq_shift;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
			val_q <= {val_q[2*RootW-3:0], 2'b00};
		end
		if (cmd.next_comp)
			rms_q[comp_q] <= (div_cnt == '0) ? '0 : root_q[ResidW-1:0];
	end

	// The divider's final step writes the full quotient into val_q; the
	// quotient fits 2*RootW bits since squares are below 2^40 each.
	always_comb begin
		over = (cfg.limit_x != '0 && rms_q[0] > cfg.limit_x)
			|| (cfg.limit_y != '0 && rms_q[1] > cfg.limit_y)
			|| (cfg.limit_z != '0 && rms_q[2] > cfg.limit_z)
			|| (cfg.limit_f != '0 && rms_q[3] > cfg.limit_f);
		if (cfg.limit_f != '0 && cnts_q < cfg.min_scalar_count)
			verdict = VERDICT_FEW;
		else if (over)
			verdict = VERDICT_LIMIT;
		else
			verdict = VERDICT_PASS;
	end

	assign sts.last_done = last_s1;
	assign sts.comp = comp_q;
	assign res_data = {4'd0, verdict, cntv_q, cnts_q,
		rms_q[3], rms_q[2], rms_q[1], rms_q[0]};
endmodule

// ===== design/trqc_ctrl.sv =====
// Controller sequencing accumulation, division, square root and output.
module trqc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  trqc_pkg::sts_t sts,
	output trqc_pkg::cmd_t cmd
);
	import trqc_pkg::*;

	typedef enum logic [6:0] {
		ST_ACC = 7'b0000001,
		ST_WAIT = 7'b0000010,
		ST_LOAD = 7'b0000100,
		ST_DIV = 7'b0001000,
		ST_SQRT = 7'b0010000,
		ST_STORE = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [5:0] step_q;

	assign in_ready = (state_q == ST_ACC);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.accum = in_valid && in_ready;
		cmd.load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.next_comp = (state_q == ST_STORE);
		cmd.clear = (state_q == ST_OUT) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_ACC: if (in_valid && in_last) state_q <= ST_WAIT;
				ST_WAIT: if (sts.last_done) state_q <= ST_LOAD;
				ST_LOAD: begin
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 6'(SumW-1)) begin
						step_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_SQRT: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(RootW-1)) state_q <= ST_STORE;
				end
				ST_STORE: state_q <= (sts.comp == 2'd3) ? ST_OUT : ST_LOAD;
				ST_OUT: if (out_ready) state_q <= ST_ACC;
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule

// ===== design/track_rms_quality_check_unit.sv =====
// Top level of the track rms quality check.
// Samples enter on the s_axis channel one beat per cycle. Each kept sample's
// squared residuals are summed into exact 51-bit accumulators. A beat with
// tlast ends the track: input stalls while four rms values are formed one
// after the other by a shared restoring divider (one quotient bit a cycle)
// and a restoring square root (one root bit a cycle). Each component goes
// through a load, the divide steps, the root steps and a store, and the
// result appears on m_axis after the fourth store. The result then sits on
// m_axis until taken; the receiver may stall as long as it likes, the
// accumulators clear when the beat is accepted and input resumes in the next
// cycle. Reset clears accumulators and counts and loads register defaults.
// The user must write registers over the APB port only while idle; unenforced.
module track_rms_quality_check_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// resid_x, resid_y, resid_z, resid_f, latitude
	input  logic [95:0] s_axis_tdata,
	// bad_sample, has_vector
	input  logic [1:0] s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// rms_x, rms_y, rms_z, rms_f, scalar_count, vector_count, verdict
	output logic [111:0] m_axis_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import trqc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	trqc_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	trqc_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .sts, .cmd);

	trqc_datapath u_dp (.clk, .arst_n, .cfg, .cmd, .sts,
		.in_data({4'd0, s_axis_tlast, s_axis_tuser, s_axis_tdata[93:0]}),
		.res_data(m_axis_tdata));
endmodule

// ===== design/trqc_checker.sv =====
// Port-level checker for the track rms quality check, with its bind.
module trqc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [111:0] m_axis_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input open during output");
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input not stopped after last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[107:106] != 2'd3) else $error("bad verdict");
endmodule

bind track_rms_quality_check_unit trqc_checker u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
